FILE: design/hash_preimage_search_top_defines.svh
// ----------------------------------------------------------------------------
// hash preimage search assertion macros
// clocked concurrent assertion helpers, disabled while reset is asserted
// ----------------------------------------------------------------------------
`ifndef HASH_PREIMAGE_SEARCH_TOP_DEFINES_SVH
`define HASH_PREIMAGE_SEARCH_TOP_DEFINES_SVH

// property that must hold at every edge
`define HPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define HPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/hps_pkg.sv
// ----------------------------------------------------------------------------
// hps_pkg
// shared constants, types and helper functions of the hash preimage search
// ----------------------------------------------------------------------------
package hps_pkg;

  localparam int unsigned MaxLen        = 10;
  localparam int unsigned NumTargets    = 6;
  localparam int unsigned SymW          = 6;
  localparam int unsigned HashW         = 28;
  localparam int unsigned CodeW         = MaxLen * SymW;
  localparam int unsigned LenW          = 4;
  localparam int unsigned CntW          = 3;
  localparam int unsigned IdxW          = 3;
  localparam int unsigned CharsPerStage = 2;
  localparam int unsigned NumStages     = (MaxLen + CharsPerStage - 1) / CharsPerStage;
  localparam int unsigned FifoDepth     = 4;
  localparam int unsigned FifoPtrW      = $clog2(FifoDepth);
  localparam int unsigned NumRegs       = 8;
  localparam int unsigned DataW         = 32;
  localparam int unsigned AddrW         = $clog2(NumRegs * 4);

  localparam logic [LenW-1:0]     MaxLenVal     = MaxLen[LenW-1:0];
  localparam logic [CntW-1:0]     NumTargetsVal = NumTargets[CntW-1:0];
  localparam logic [FifoPtrW:0]   FifoFullCnt   = FifoDepth[FifoPtrW:0];

  localparam logic [SymW-1:0] SymUpper     = 6'd10;
  localparam logic [SymW-1:0] SymLower     = 6'd36;
  localparam logic [SymW-1:0] SymLast      = 6'd62;
  localparam logic [SymW-1:0] SymFirstLead = 6'd10;

  localparam logic [7:0] AsciiDigitBase = 8'h30;
  localparam logic [7:0] AsciiUpperOfs  = 8'd55;
  localparam logic [7:0] AsciiLowerOfs  = 8'd61;
  localparam logic [7:0] AsciiUnderline = 8'h5f;

  typedef enum logic [2:0] {
    RegStringLength,
    RegTargetCount,
    RegTargetZero,
    RegTargetOne,
    RegTargetTwo,
    RegTargetThree,
    RegTargetFour,
    RegTargetFive
  } reg_idx_e;

  typedef struct packed {
    logic [LenW-1:0]                     len;
    logic [CntW-1:0]                     count;
    logic [NumTargets-1:0][HashW-1:0]    targets;
  } cfg_t;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [LenW-1:0]  len;
    logic             last;
  } entry_t;

  typedef struct packed {
    logic [HashW-1:0] hash;
    logic [CodeW-1:0] code;
    logic [LenW-1:0]  len;
    logic             last;
  } stage_t;

  typedef struct packed {
    logic             matched;
    logic [IdxW-1:0]  target_index;
    logic [CodeW-1:0] code;
    logic [HashW-1:0] hash;
    logic             exhausted;
  } result_t;

  function automatic logic [7:0] sym_ascii(logic [SymW-1:0] s);
    logic [7:0] s8;
    s8 = {2'b00, s};
    if (s < SymUpper) begin
      return AsciiDigitBase + s8;
    end else if (s < SymLower) begin
      return AsciiUpperOfs + s8;
    end else if (s < SymLast) begin
      return AsciiLowerOfs + s8;
    end
    return AsciiUnderline;
  endfunction

  // hash * 33 + ascii, wrapping at the hash width
  function automatic logic [HashW-1:0] hash_step(logic [HashW-1:0] h, logic [SymW-1:0] s);
    logic [HashW-1:0] asc;
    asc = {{(HashW - 8){1'b0}}, sym_ascii(s)};
    return {h[HashW-6:0], 5'b00000} + h + asc;
  endfunction

  function automatic stage_t stage_calc(stage_t s, int unsigned base);
    stage_t      r;
    int unsigned ci;
    r = s;
    for (int unsigned j = 0; j < CharsPerStage; j++) begin
      ci = base + j;
      if ((ci < MaxLen) && (ci < s.len)) begin
        r.hash = hash_step(r.hash, s.code[ci*SymW +: SymW]);
      end
    end
    return r;
  endfunction

endpackage

FILE: design/hps_front.sv
// ----------------------------------------------------------------------------
// hps_front
// holds the candidate string, applies restart and advances it per transaction
// ----------------------------------------------------------------------------
module hps_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            restart_i,
  output logic                            in_stall_o,
  input  logic [hps_pkg::LenW-1:0]        len_i,
  input  logic                            full_i,
  output logic                            push_o,
  output hps_pkg::entry_t                 entry_o
);

  logic [hps_pkg::SymW-1:0] sym_q [hps_pkg::MaxLen];
  logic [hps_pkg::SymW-1:0] sym_d [hps_pkg::MaxLen];
  logic [hps_pkg::SymW-1:0] cur   [hps_pkg::MaxLen];
  logic                     carry;
  logic                     last;
  logic                     accept;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;

  always_comb begin
    entry_o.code = '0;
    last         = 1'b1;
    carry        = 1'b1;
    for (int i = 0; i < hps_pkg::MaxLen; i++) begin
      if (restart_i) begin
        cur[i] = (i == 0) ? hps_pkg::SymFirstLead : '0;
      end else begin
        cur[i] = sym_q[i];
      end
    end
    for (int i = 0; i < hps_pkg::MaxLen; i++) begin
      sym_d[i] = cur[i];
      if (i < int'(len_i)) begin
        entry_o.code[i*hps_pkg::SymW +: hps_pkg::SymW] = cur[i];
        if (cur[i] < hps_pkg::SymLast) begin
          last = 1'b0;
        end
        if (carry) begin
          if (cur[i] >= hps_pkg::SymLast) begin
            sym_d[i] = (i == 0) ? hps_pkg::SymFirstLead : '0;
          end else begin
            sym_d[i] = cur[i] + 1'b1;
            carry    = 1'b0;
          end
        end
      end
    end
    entry_o.len  = len_i;
    entry_o.last = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < hps_pkg::MaxLen; i++) begin
        sym_q[i] <= (i == 0) ? hps_pkg::SymFirstLead : '0;
      end
    end else if (accept) begin
      sym_q <= sym_d;
    end
  end

endmodule

FILE: design/hps_fifo.sv
// ----------------------------------------------------------------------------
// hps_fifo
// short queue between the candidate front end and the hash pipeline
// ----------------------------------------------------------------------------
module hps_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  hps_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output hps_pkg::entry_t entry_o
);

  hps_pkg::entry_t              mem_q [hps_pkg::FifoDepth];
  logic [hps_pkg::FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [hps_pkg::FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [hps_pkg::FifoPtrW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == hps_pkg::FifoFullCnt);
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

FILE: design/hps_back.sv
// ----------------------------------------------------------------------------
// hps_back
// pipelined hash over the candidate, target match and output register
// ----------------------------------------------------------------------------
`include "hash_preimage_search_top_defines.svh"

module hps_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  hps_pkg::cfg_t                    cfg_i,
  input  logic                             valid_i,
  input  hps_pkg::entry_t                  entry_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             matched_o,
  output logic [hps_pkg::IdxW-1:0]         target_index_o,
  output logic [hps_pkg::CodeW-1:0]        candidate_code_o,
  output logic [hps_pkg::HashW-1:0]        hash_value_o,
  output logic                             exhausted_o
);

  localparam int unsigned LastStg = hps_pkg::NumStages - 1;

  hps_pkg::stage_t  p_q     [hps_pkg::NumStages];
  logic             pv_q    [hps_pkg::NumStages];
  hps_pkg::stage_t  stg_in  [hps_pkg::NumStages];
  hps_pkg::stage_t  stg_out [hps_pkg::NumStages];
  logic             stg_vin [hps_pkg::NumStages];
  logic             en      [hps_pkg::NumStages + 1];
  hps_pkg::result_t res;
  hps_pkg::result_t out_q;
  logic             out_valid_q;

  always_comb begin
    en[hps_pkg::NumStages] = !out_valid_q || !out_stall_i;
    for (int k = hps_pkg::NumStages - 1; k >= 0; k--) begin
      en[k] = !pv_q[k] || en[k+1];
    end
  end

  assign pop_o = valid_i && en[0];

  for (genvar g = 0; g < hps_pkg::NumStages; g++) begin : g_stage
    if (g == 0) begin : g_head
      assign stg_in[g].hash = '0;
      assign stg_in[g].code = entry_i.code;
      assign stg_in[g].len  = entry_i.len;
      assign stg_in[g].last = entry_i.last;
      assign stg_vin[g]     = valid_i;
    end else begin : g_body
      assign stg_in[g]  = p_q[g-1];
      assign stg_vin[g] = pv_q[g-1];
    end
    assign stg_out[g] = hps_pkg::stage_calc(stg_in[g], g * hps_pkg::CharsPerStage);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < hps_pkg::NumStages; k++) begin
        pv_q[k] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else begin
      for (int k = 0; k < hps_pkg::NumStages; k++) begin
        if (en[k]) begin
          pv_q[k] <= stg_vin[k];
        end
      end
      if (en[hps_pkg::NumStages]) begin
        out_valid_q <= pv_q[LastStg];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < hps_pkg::NumStages; k++) begin
      if (en[k]) begin
        p_q[k] <= stg_out[k];
      end
    end
    if (en[hps_pkg::NumStages]) begin
      out_q <= res;
    end
  end

  // lowest active index wins
  always_comb begin
    res.matched      = 1'b0;
    res.target_index = '0;
    res.code         = p_q[LastStg].code;
    res.hash         = p_q[LastStg].hash;
    res.exhausted    = p_q[LastStg].last;
    for (int t = hps_pkg::NumTargets - 1; t >= 0; t--) begin
      if ((t < int'(cfg_i.count)) && (cfg_i.targets[t] == p_q[LastStg].hash)) begin
        res.matched      = 1'b1;
        res.target_index = t[hps_pkg::IdxW-1:0];
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign matched_o        = out_q.matched;
  assign target_index_o   = out_q.target_index;
  assign candidate_code_o = out_q.code;
  assign hash_value_o     = out_q.hash;
  assign exhausted_o      = out_q.exhausted;

  `HPS_ASSERT_NEXT(a_tail_hold, pv_q[LastStg] && !en[hps_pkg::NumStages], pv_q[LastStg] && $stable(p_q[LastStg]), "tail stage lost data while output stalled")
  `HPS_ASSERT(a_idx_zero, out_valid_q && !out_q.matched |-> out_q.target_index == '0, "index set without match")
  `HPS_ASSERT(a_idx_active, out_valid_q && out_q.matched |-> out_q.target_index < cfg_i.count, "match on inactive target")
  `HPS_ASSERT(a_len_range, pv_q[0] |-> p_q[0].len != '0 && p_q[0].len <= hps_pkg::MaxLenVal, "length out of range in pipeline")

endmodule

FILE: design/hash_preimage_search_top.sv
// ----------------------------------------------------------------------------
// hash_preimage_search_top
// result path: accepted transaction, queue, hash stages, output register
// throughput: one candidate per cycle unless the output stalls, set by the
// 5-stage hash pipeline (two characters per stage), fed by a 4-entry queue
// reset: string length 1, target count 1, targets 0, first candidate loaded
// ----------------------------------------------------------------------------
module hash_preimage_search_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [hps_pkg::AddrW-1:0]        paddr,
  input  logic [hps_pkg::DataW-1:0]        pwdata,
  output logic [hps_pkg::DataW-1:0]        prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             restart_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             matched_o,
  output logic [hps_pkg::IdxW-1:0]         target_index_o,
  output logic [hps_pkg::CodeW-1:0]        candidate_code_o,
  output logic [hps_pkg::HashW-1:0]        hash_value_o,
  output logic                             exhausted_o
);

  localparam int unsigned HashPad = hps_pkg::DataW - hps_pkg::HashW;

  logic [hps_pkg::LenW-1:0]  len_q;
  logic [hps_pkg::CntW-1:0]  cnt_q;
  logic [hps_pkg::HashW-1:0] tgt_q [hps_pkg::NumTargets];
  hps_pkg::reg_idx_e         reg_idx;
  logic                      wr_en;
  hps_pkg::cfg_t             cfg;
  logic                      push;
  logic                      full;
  logic                      pop;
  logic                      fifo_valid;
  hps_pkg::entry_t           entry_in;
  hps_pkg::entry_t           entry_out;

  assign pready  = 1'b1;
  assign reg_idx = hps_pkg::reg_idx_e'(paddr[hps_pkg::AddrW-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= hps_pkg::LenW'(1);
      cnt_q <= hps_pkg::CntW'(1);
      for (int t = 0; t < hps_pkg::NumTargets; t++) begin
        tgt_q[t] <= '0;
      end
    end else if (wr_en) begin
      unique case (reg_idx)
        hps_pkg::RegStringLength: len_q    <= pwdata[hps_pkg::LenW-1:0];
        hps_pkg::RegTargetCount:  cnt_q    <= pwdata[hps_pkg::CntW-1:0];
        hps_pkg::RegTargetZero:   tgt_q[0] <= pwdata[hps_pkg::HashW-1:0];
        hps_pkg::RegTargetOne:    tgt_q[1] <= pwdata[hps_pkg::HashW-1:0];
        hps_pkg::RegTargetTwo:    tgt_q[2] <= pwdata[hps_pkg::HashW-1:0];
        hps_pkg::RegTargetThree:  tgt_q[3] <= pwdata[hps_pkg::HashW-1:0];
        hps_pkg::RegTargetFour:   tgt_q[4] <= pwdata[hps_pkg::HashW-1:0];
        hps_pkg::RegTargetFive:   tgt_q[5] <= pwdata[hps_pkg::HashW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      hps_pkg::RegStringLength: prdata = {{(hps_pkg::DataW - hps_pkg::LenW){1'b0}}, len_q};
      hps_pkg::RegTargetCount:  prdata = {{(hps_pkg::DataW - hps_pkg::CntW){1'b0}}, cnt_q};
      hps_pkg::RegTargetZero:   prdata = {{HashPad{1'b0}}, tgt_q[0]};
      hps_pkg::RegTargetOne:    prdata = {{HashPad{1'b0}}, tgt_q[1]};
      hps_pkg::RegTargetTwo:    prdata = {{HashPad{1'b0}}, tgt_q[2]};
      hps_pkg::RegTargetThree:  prdata = {{HashPad{1'b0}}, tgt_q[3]};
      hps_pkg::RegTargetFour:   prdata = {{HashPad{1'b0}}, tgt_q[4]};
      hps_pkg::RegTargetFive:   prdata = {{HashPad{1'b0}}, tgt_q[5]};
      default:                  prdata = '0;
    endcase
  end

  // clamp length and count into their usable ranges
  always_comb begin
    if (len_q == '0) begin
      cfg.len = hps_pkg::LenW'(1);
    end else if (len_q > hps_pkg::MaxLenVal) begin
      cfg.len = hps_pkg::MaxLenVal;
    end else begin
      cfg.len = len_q;
    end
    cfg.count = (cnt_q > hps_pkg::NumTargetsVal) ? hps_pkg::NumTargetsVal : cnt_q;
    for (int t = 0; t < hps_pkg::NumTargets; t++) begin
      cfg.targets[t] = tgt_q[t];
    end
  end

  hps_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .restart_i  (restart_i),
    .in_stall_o (in_stall_o),
    .len_i      (cfg.len),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (entry_in)
  );

  hps_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .entry_o (entry_out)
  );

  hps_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .valid_i          (fifo_valid),
    .entry_i          (entry_out),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .matched_o        (matched_o),
    .target_index_o   (target_index_o),
    .candidate_code_o (candidate_code_o),
    .hash_value_o     (hash_value_o),
    .exhausted_o      (exhausted_o)
  );

endmodule
